// File: rtl/rpp_pkg.sv
// Shared types and constants for the RTP packet parser.
`timescale 1ns / 1ps

package rpp_pkg;

	localparam int unsigned MAX_PACKET_BYTES = 65535;
	localparam logic [15:0] MAX_BYTES        = 16'(MAX_PACKET_BYTES);
	localparam logic [15:0] HDR_BYTES        = 16'd12;
	localparam logic [1:0]  RTP_VERSION      = 2'd2;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] KIND_HEADER  = 3'd0;
	localparam logic [2:0] KIND_CSRC    = 3'd1;
	localparam logic [2:0] KIND_EXTHDR  = 3'd2;
	localparam logic [2:0] KIND_EXTWORD = 3'd3;
	localparam logic [2:0] KIND_PAYLOAD = 3'd4;
	localparam logic [2:0] KIND_END     = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_VERSION   = 3'd2;
	localparam logic [2:0] ST_TRUNCATED = 3'd3;
	localparam logic [2:0] ST_PADDING   = 3'd4;
	localparam logic [2:0] ST_TOO_LONG  = 3'd5;

	typedef enum logic [5:0] {
		PH_HEADER  = 6'b000001,
		PH_CSRC    = 6'b000010,
		PH_EXTHDR  = 6'b000100,
		PH_EXTWORD = 6'b001000,
		PH_BODY    = 6'b010000,
		PH_DRAIN   = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] value_a;
		logic [31:0] value_b;
		logic [15:0] value_16;
		logic        marker;
		logic [6:0]  ptype;
		logic        padding;
		logic        extension;
		logic [3:0]  src_cnt;
		logic [2:0]  status;
		logic [7:0]  pad;
		logic        done;
	} rec_t;

endpackage

// File: rtl/rtp_packet_parser.sv
// RTP packet parser top level: header, CSRC, extension and payload extraction.
`timescale 1ns / 1ps

// Takes one RTP packet byte per beat, end_of_packet set on the final byte, and
// sends one record per beat: the fixed header once twelve bytes are in, each CSRC
// word, the extension header, each extension word, each payload byte (padding
// included), and an end record with status, padding size and payload length on
// the final byte. A byte is registered, then decoded from that register into at
// most two records written to a four-entry result queue; a record is on the
// output from the cycle after its byte is decoded. The input takes one byte per
// cycle while the queue has room for two records; the final byte can add an end
// record to the record it completes, so the input stalls while more than two
// records wait. The parser state returns to its reset value after each end
// record.
module rtp_packet_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_packet,
	output logic        rec_valid,
	input  logic        rec_ready,
	output logic [2:0]  rec_kind,
	output logic [31:0] value_a,
	output logic [31:0] value_b,
	output logic [15:0] value_16,
	output logic        marker_bit,
	output logic [6:0]  payload_kind,
	output logic        has_padding,
	output logic        has_extension,
	output logic [3:0]  source_count,
	output logic [2:0]  parse_status,
	output logic [7:0]  pad_bytes,
	output logic        packet_done
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic [15:0]           off_q, off_n;
	rpp_pkg::phase_t       ph_q, ph_n;
	logic [31:0]           ws_q, ws_n;
	logic [15:0]           ftb_q, ftb_n;
	logic [47:0]           st_q, st_n;
	logic [3:0]            csrc_q, csrc_n;
	logic [15:0]           ext_q, ext_n;
	logic [15:0]           bs_q, bs_n;
	logic [2:0]            err_q, err_n;

	logic                  byte_vld;
	rpp_pkg::rec_t         byte_rec;
	rpp_pkg::rec_t         end_rec;
	logic [15:0]           count;
	logic                  consume;

	rpp_pkg::rec_t                   q_mem [rpp_pkg::QUEUE_DEPTH];
	logic [rpp_pkg::QPTR_W-1:0]      wr_q, rd_q;
	logic [rpp_pkg::QCNT_W-1:0]      cnt_q;
	logic [1:0]                      push;
	logic                            pop;
	rpp_pkg::rec_t                   head;

	assign consume    = valid_s1 &&
		(cnt_q <= rpp_pkg::QCNT_W'(rpp_pkg::QUEUE_DEPTH - 2));
	assign data_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_ready) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_ready && data_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= end_of_packet;
		end
	end

	always_comb begin
		off_n    = off_q;
		ph_n     = ph_q;
		ws_n     = ws_q;
		ftb_n    = ftb_q;
		st_n     = st_q;
		csrc_n   = csrc_q;
		ext_n    = ext_q;
		bs_n     = bs_q;
		err_n    = err_q;
		byte_vld = 1'b0;
		byte_rec = '0;
		end_rec  = '0;
		count    = '0;

		if (off_q >= rpp_pkg::MAX_BYTES) begin
			if (err_q == rpp_pkg::ST_OK) begin
				err_n = rpp_pkg::ST_TOO_LONG;
			end
			ph_n = rpp_pkg::PH_DRAIN;
		end else begin
			off_n = 16'(off_q + 16'd1);
			ws_n  = {ws_q[23:0], byte_s1};
			case (ph_q)
				rpp_pkg::PH_HEADER: begin
					if (off_q < 16'd2) begin
						ftb_n = {ftb_q[7:0], byte_s1};
						if (off_q == 16'd0 && byte_s1[7:6] != rpp_pkg::RTP_VERSION) begin
							err_n = rpp_pkg::ST_VERSION;
							ph_n  = rpp_pkg::PH_DRAIN;
						end
					end else if (off_q < 16'd8) begin
						st_n = {st_q[39:0], byte_s1};
					end else if (off_q == 16'd11) begin
						byte_vld            = 1'b1;
						byte_rec.kind       = rpp_pkg::KIND_HEADER;
						byte_rec.value_a    = st_q[31:0];
						byte_rec.value_b    = ws_n;
						byte_rec.value_16   = st_q[47:32];
						byte_rec.marker     = ftb_q[7];
						byte_rec.ptype      = ftb_q[6:0];
						byte_rec.padding    = ftb_q[13];
						byte_rec.extension  = ftb_q[12];
						byte_rec.src_cnt    = ftb_q[11:8];
						csrc_n              = ftb_q[11:8];
						if (ftb_q[11:8] != 4'd0) begin
							ph_n = rpp_pkg::PH_CSRC;
						end else if (ftb_q[12]) begin
							ph_n = rpp_pkg::PH_EXTHDR;
						end else begin
							ph_n = rpp_pkg::PH_BODY;
							bs_n = off_n;
						end
					end
				end
				rpp_pkg::PH_CSRC: begin
					if (off_q[1:0] == 2'd3) begin
						byte_vld         = 1'b1;
						byte_rec.kind    = rpp_pkg::KIND_CSRC;
						byte_rec.value_a = ws_n;
						csrc_n           = 4'(csrc_q - 4'd1);
						if (csrc_q == 4'd1) begin
							if (ftb_q[12]) begin
								ph_n = rpp_pkg::PH_EXTHDR;
							end else begin
								ph_n = rpp_pkg::PH_BODY;
								bs_n = off_n;
							end
						end
					end
				end
				rpp_pkg::PH_EXTHDR: begin
					if (off_q[1:0] == 2'd3) begin
						byte_vld          = 1'b1;
						byte_rec.kind     = rpp_pkg::KIND_EXTHDR;
						byte_rec.value_a  = {16'd0, ws_n[15:0]};
						byte_rec.value_16 = ws_n[31:16];
						ext_n             = ws_n[15:0];
						if (ws_n[15:0] == 16'd0) begin
							ph_n = rpp_pkg::PH_BODY;
							bs_n = off_n;
						end else begin
							ph_n = rpp_pkg::PH_EXTWORD;
						end
					end
				end
				rpp_pkg::PH_EXTWORD: begin
					if (off_q[1:0] == 2'd3) begin
						byte_vld         = 1'b1;
						byte_rec.kind    = rpp_pkg::KIND_EXTWORD;
						byte_rec.value_a = ws_n;
						ext_n            = 16'(ext_q - 16'd1);
						if (ext_q == 16'd1) begin
							ph_n = rpp_pkg::PH_BODY;
							bs_n = off_n;
						end
					end
				end
				rpp_pkg::PH_BODY: begin
					byte_vld         = 1'b1;
					byte_rec.kind    = rpp_pkg::KIND_PAYLOAD;
					byte_rec.value_a = {24'd0, byte_s1};
				end
				default: begin
				end
			endcase
		end

		end_rec.kind = rpp_pkg::KIND_END;
		end_rec.done = 1'b1;
		if (off_n < rpp_pkg::HDR_BYTES) begin
			end_rec.status = rpp_pkg::ST_SHORT;
		end else if (err_n != rpp_pkg::ST_OK) begin
			end_rec.status = err_n;
		end else if (ph_n != rpp_pkg::PH_BODY) begin
			end_rec.status = rpp_pkg::ST_TRUNCATED;
		end else begin
			count          = 16'(off_n - bs_n);
			end_rec.status = rpp_pkg::ST_OK;
			if (ftb_n[13]) begin
				end_rec.pad = byte_s1;
				if (byte_s1 == 8'd0 || {8'd0, byte_s1} > count) begin
					end_rec.status = rpp_pkg::ST_PADDING;
				end else begin
					end_rec.value_16 = 16'(count - {8'd0, byte_s1});
				end
			end else begin
				end_rec.value_16 = count;
			end
		end

		if (last_s1) begin
			off_n  = '0;
			ph_n   = rpp_pkg::PH_HEADER;
			ws_n   = '0;
			ftb_n  = '0;
			st_n   = '0;
			csrc_n = '0;
			ext_n  = '0;
			bs_n   = '0;
			err_n  = rpp_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= '0;
			ph_q   <= rpp_pkg::PH_HEADER;
			ws_q   <= '0;
			ftb_q  <= '0;
			st_q   <= '0;
			csrc_q <= '0;
			ext_q  <= '0;
			bs_q   <= '0;
			err_q  <= rpp_pkg::ST_OK;
		end else if (consume) begin
			off_q  <= off_n;
			ph_q   <= ph_n;
			ws_q   <= ws_n;
			ftb_q  <= ftb_n;
			st_q   <= st_n;
			csrc_q <= csrc_n;
			ext_q  <= ext_n;
			bs_q   <= bs_n;
			err_q  <= err_n;
		end
	end

	assign push = consume ? (2'({1'b0, byte_vld}) + 2'({1'b0, last_s1})) : 2'd0;
	assign pop  = rec_valid && rec_ready;

	always_ff @(posedge clk) begin
		if (push != 2'd0) begin
			q_mem[wr_q] <= byte_vld ? byte_rec : end_rec;
		end
		if (push == 2'd2) begin
			q_mem[rpp_pkg::QPTR_W'(wr_q + 1'b1)] <= end_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= rpp_pkg::QPTR_W'(wr_q + rpp_pkg::QPTR_W'(push));
			rd_q  <= rpp_pkg::QPTR_W'(rd_q + rpp_pkg::QPTR_W'(pop));
			cnt_q <= rpp_pkg::QCNT_W'(cnt_q + rpp_pkg::QCNT_W'(push)
				- rpp_pkg::QCNT_W'(pop));
		end
	end

	assign head          = q_mem[rd_q];
	assign rec_valid     = (cnt_q != '0);
	assign rec_kind      = head.kind;
	assign value_a       = head.value_a;
	assign value_b       = head.value_b;
	assign value_16      = head.value_16;
	assign marker_bit    = head.marker;
	assign payload_kind  = head.ptype;
	assign has_padding   = head.padding;
	assign has_extension = head.extension;
	assign source_count  = head.src_cnt;
	assign parse_status  = head.status;
	assign pad_bytes     = head.pad;
	assign packet_done   = head.done;

endmodule

// File: rtl/rpp_checker.sv
// Port-level checks for the RTP packet parser and their bind to the top level.
`timescale 1ns / 1ps

module rpp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rec_valid,
	input logic        rec_ready,
	input logic [2:0]  rec_kind,
	input logic [31:0] value_a,
	input logic [2:0]  parse_status,
	input logic [7:0]  pad_bytes,
	input logic        packet_done
);

	a_rec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !rec_ready |=> rec_valid && $stable(rec_kind) && $stable(value_a))
		else $error("record changed while stalled");

	a_done_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid |-> (packet_done == (rec_kind == rpp_pkg::KIND_END)))
		else $error("packet_done does not match end record");

	a_status_end_only: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_kind != rpp_pkg::KIND_END |->
			parse_status == rpp_pkg::ST_OK && pad_bytes == 8'd0)
		else $error("status or pad on a non-end record");

	a_end_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_kind == rpp_pkg::KIND_END |-> value_a == 32'd0)
		else $error("end record carries a value");

endmodule

bind rtp_packet_parser rpp_checker u_rpp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rec_valid    (rec_valid),
	.rec_ready    (rec_ready),
	.rec_kind     (rec_kind),
	.value_a      (value_a),
	.parse_status (parse_status),
	.pad_bytes    (pad_bytes),
	.packet_done  (packet_done)
);
